/* rtl/core/ufds_pkg.sv */
// Shared types, constants and the engine state type for the disjoint-set block.
// No dependencies.
package ufds_pkg;

    localparam int IDX_W            = 10;
    localparam int COUNT_W          = 11;
    localparam int RANK_W           = 4;
    localparam int NUM_ELEMENTS_DEF = 1024;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
    localparam logic [RANK_W-1:0]  RANK_MAX    = 4'd15;

    localparam logic OP_FIND  = 1'b0;
    localparam logic OP_UNION = 1'b1;

    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] second;
        logic             err;
    } t_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_COMP_RD,
        ST_COMP_CHK,
        ST_RANK_A,
        ST_RANK_B
    } t_state;

endpackage

/* rtl/core/ufds_front.sv */
// Front end: takes input transfers, range-checks indices, pushes requests.
// Depends on ufds_pkg.
module ufds_front #(
    parameter int NUM_ELEMENTS = ufds_pkg::NUM_ELEMENTS_DEF
) (
    input  logic                         i_tvalid,
    output logic                         o_tready,
    input  logic [23:0]                  i_tdata,
    input  logic                         i_tuser,
    input  logic [ufds_pkg::COUNT_W-1:0] i_count,
    input  logic                         i_q_full,
    output logic                         o_push,
    output ufds_pkg::t_req               o_req
);
    logic [ufds_pkg::IDX_W-1:0] w_a;
    logic [ufds_pkg::IDX_W-1:0] w_b;
    logic                       w_a_bad;
    logic                       w_b_bad;

    assign w_a = i_tdata[9:0];
    assign w_b = i_tdata[19:10];

    // in range only below both the register and the table depth
    assign w_a_bad = ({1'b0, w_a} >= i_count) || (32'(w_a) >= NUM_ELEMENTS);
    assign w_b_bad = ({1'b0, w_b} >= i_count) || (32'(w_b) >= NUM_ELEMENTS);

    assign o_tready = !i_q_full;
    assign o_push   = i_tvalid && !i_q_full;

    always_comb begin
        o_req.op     = i_tuser;
        o_req.first  = w_a;
        o_req.second = w_b;
        o_req.err    = (i_tuser == ufds_pkg::OP_UNION) ? (w_a_bad || w_b_bad) : w_a_bad;
    end
endmodule

/* rtl/core/ufds_queue.sv */
// Two-entry request queue between front end and engine.
// Depends on ufds_pkg.
module ufds_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ufds_pkg::t_req i_req,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ufds_pkg::t_req o_req
);
    ufds_pkg::t_req r_mem [2];
    logic           r_wp, n_wp;
    logic           r_rp, n_rp;
    logic [1:0]     r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp ^ i_push;
        n_rp  = r_rp ^ i_pop;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_req;
        end
    end
endmodule

/* rtl/core/ufds_engine.sv */
// Back end: parent/rank memories, root walk with path compression, union link,
// result register. Depends on ufds_pkg.
module ufds_engine #(
    parameter int NUM_ELEMENTS = ufds_pkg::NUM_ELEMENTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  ufds_pkg::t_req             i_req,
    output logic                       o_pop,
    output logic                       o_tvalid,
    input  logic                       i_tready,
    output logic [ufds_pkg::IDX_W-1:0] o_root,
    output logic                       o_joined,
    output logic                       o_err
);
    localparam int IW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
    localparam int RW = ufds_pkg::RANK_W;

    logic [IW-1:0] parent_mem [NUM_ELEMENTS];
    logic [RW-1:0] rank_mem   [NUM_ELEMENTS];

    ufds_pkg::t_state r_state, n_state;

    logic [IW-1:0] r_node, n_node;
    logic [IW-1:0] r_start, n_start;
    logic [IW-1:0] r_top, n_top;
    logic [IW-1:0] r_ra, n_ra;
    logic [IW-1:0] r_second, n_second;
    logic          r_op, n_op;
    logic          r_phase, n_phase;
    logic [RW-1:0] r_rank_a, n_rank_a;
    logic [IW-1:0] r_clr, n_clr;

    logic [IW-1:0] r_pdata;
    logic [RW-1:0] r_rdata;
    logic [IW-1:0] w_p_ra;
    logic [IW-1:0] w_r_ra;
    logic          w_p_we;
    logic [IW-1:0] w_p_wa, w_p_wd;
    logic          w_r_we;
    logic [IW-1:0] w_r_wa;
    logic [RW-1:0] w_r_wd;

    logic                       r_out_valid, n_out_valid;
    logic [ufds_pkg::IDX_W-1:0] r_root, n_root;
    logic                       r_joined, n_joined;
    logic                       r_err, n_err;

    assign o_tvalid = r_out_valid;
    assign o_root   = r_root;
    assign o_joined = r_joined;
    assign o_err    = r_err;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ufds_pkg::ST_CLEAR: begin
                if (r_clr == IW'(NUM_ELEMENTS - 1)) n_state = ufds_pkg::ST_IDLE;
            end
            ufds_pkg::ST_IDLE: begin
                if (i_q_valid && !r_out_valid && !i_req.err) n_state = ufds_pkg::ST_WALK_RD;
            end
            ufds_pkg::ST_WALK_RD:  n_state = ufds_pkg::ST_WALK_CHK;
            ufds_pkg::ST_WALK_CHK: begin
                if (r_pdata == r_node) n_state = ufds_pkg::ST_COMP_RD;
                else                   n_state = ufds_pkg::ST_WALK_RD;
            end
            ufds_pkg::ST_COMP_RD: begin
                if (r_node != r_top)                      n_state = ufds_pkg::ST_COMP_CHK;
                else if (r_op == ufds_pkg::OP_FIND)       n_state = ufds_pkg::ST_IDLE;
                else if (!r_phase)                        n_state = ufds_pkg::ST_WALK_RD;
                else if (r_ra == r_top)                   n_state = ufds_pkg::ST_IDLE;
                else                                      n_state = ufds_pkg::ST_RANK_A;
            end
            ufds_pkg::ST_COMP_CHK: n_state = ufds_pkg::ST_COMP_RD;
            ufds_pkg::ST_RANK_A:   n_state = ufds_pkg::ST_RANK_B;
            ufds_pkg::ST_RANK_B:   n_state = ufds_pkg::ST_IDLE;
            default:               n_state = ufds_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_node      = r_node;
        n_start     = r_start;
        n_top       = r_top;
        n_ra        = r_ra;
        n_second    = r_second;
        n_op        = r_op;
        n_phase     = r_phase;
        n_rank_a    = r_rank_a;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && !i_tready;
        n_root      = r_root;
        n_joined    = r_joined;
        n_err       = r_err;
        o_pop       = 1'b0;
        w_p_ra      = r_node;
        w_r_ra      = r_ra;
        w_p_we      = 1'b0;
        w_p_wa      = r_node;
        w_p_wd      = r_top;
        w_r_we      = 1'b0;
        w_r_wa      = r_ra;
        w_r_wd      = '0;
        case (r_state)
            ufds_pkg::ST_CLEAR: begin
                w_p_we = 1'b1;
                w_p_wa = r_clr;
                w_p_wd = r_clr;
                w_r_we = 1'b1;
                w_r_wa = r_clr;
                n_clr  = r_clr + 1'b1;
            end
            ufds_pkg::ST_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    o_pop = 1'b1;
                    if (i_req.err) begin
                        n_out_valid = 1'b1;
                        n_root      = '0;
                        n_joined    = 1'b0;
                        n_err       = 1'b1;
                    end else begin
                        n_node   = IW'(i_req.first);
                        n_start  = IW'(i_req.first);
                        n_second = IW'(i_req.second);
                        n_op     = i_req.op;
                        n_phase  = 1'b0;
                    end
                end
            end
            ufds_pkg::ST_WALK_CHK: begin
                if (r_pdata == r_node) begin
                    n_top  = r_node;
                    n_node = r_start;
                end else begin
                    n_node = r_pdata;
                end
            end
            ufds_pkg::ST_COMP_RD: begin
                if (r_node == r_top) begin
                    if (r_op == ufds_pkg::OP_FIND) begin
                        n_out_valid = 1'b1;
                        n_root      = ufds_pkg::IDX_W'(r_top);
                        n_joined    = 1'b0;
                        n_err       = 1'b0;
                    end else if (!r_phase) begin
                        n_ra    = r_top;
                        n_node  = r_second;
                        n_start = r_second;
                        n_phase = 1'b1;
                    end else if (r_ra == r_top) begin
                        n_out_valid = 1'b1;
                        n_root      = ufds_pkg::IDX_W'(r_top);
                        n_joined    = 1'b1;
                        n_err       = 1'b0;
                    end
                end
            end
            ufds_pkg::ST_COMP_CHK: begin
                // point visited entry straight at the root
                w_p_we = 1'b1;
                n_node = r_pdata;
            end
            ufds_pkg::ST_RANK_A: begin
                n_rank_a = r_rdata;
                w_r_ra   = r_top;
            end
            ufds_pkg::ST_RANK_B: begin
                n_out_valid = 1'b1;
                n_joined    = 1'b0;
                n_err       = 1'b0;
                w_p_we      = 1'b1;
                if (r_rank_a < r_rdata) begin
                    w_p_wa = r_ra;
                    w_p_wd = r_top;
                    n_root = ufds_pkg::IDX_W'(r_top);
                end else begin
                    w_p_wa = r_top;
                    w_p_wd = r_ra;
                    n_root = ufds_pkg::IDX_W'(r_ra);
                    if (r_rank_a == r_rdata && r_rank_a < ufds_pkg::RANK_MAX) begin
                        w_r_we = 1'b1;
                        w_r_wa = r_ra;
                        w_r_wd = r_rank_a + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ufds_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node   <= n_node;
        r_start  <= n_start;
        r_top    <= n_top;
        r_ra     <= n_ra;
        r_second <= n_second;
        r_op     <= n_op;
        r_phase  <= n_phase;
        r_rank_a <= n_rank_a;
        r_root   <= n_root;
        r_joined <= n_joined;
        r_err    <= n_err;
    end

    always_ff @(posedge i_clk) begin
        if (w_p_we) parent_mem[w_p_wa] <= w_p_wd;
        r_pdata <= parent_mem[w_p_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_r_we) rank_mem[w_r_wa] <= w_r_wd;
        r_rdata <= rank_mem[w_r_ra];
    end
endmodule

/* rtl/core/union_find_disjoint_set_top.sv */
// Top level of the disjoint-set engine: config register, front end, queue, engine.
// Depends on ufds_pkg, ufds_front, ufds_queue, ufds_engine.
//
// Union-find engine with path compression and union by rank over NUM_ELEMENTS
// entries. After reset the block sweeps its parent and rank memories, one
// entry per cycle. During the sweep the two queue entries can fill, and after
// that no input transfer is taken until the sweep ends. Config writes are
// taken during that sweep. The walk and the path compression run through the
// single read port of the parent memory. A find runs these steps in order:
//   - pop the request from the queue;
//   - walk the links from the start entry until an entry that is its own
//     parent is seen as the root;
//   - rewrite every non-root entry on the path on the way back, pointing it
//     straight at the root, and finish the walk.
// A union walks both paths this way; when the roots differ, it then reads
// both ranks and links; when both are already joined it finishes without
// the link. Out-of-range requests are answered with the error flag from the
// idle state, without a walk. A two-entry queue decouples input acceptance
// from the engine, and the result register holds one finished transfer while
// the engine waits for it to drain.
module union_find_disjoint_set_top #(
    parameter int NUM_ELEMENTS = ufds_pkg::NUM_ELEMENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config: element_count
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [9:0] first_index, [19:10] second_index
    input  logic        s_axis_tuser,  // [0] operation
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [9:0] root, [10] already_joined
    output logic        m_axis_tuser   // [0] error
);
    logic [ufds_pkg::COUNT_W-1:0] r_count;
    logic                         w_push, w_full, w_pop, w_qv;
    ufds_pkg::t_req               w_in_req, w_q_req;
    logic [ufds_pkg::IDX_W-1:0]   w_root;
    logic                         w_joined;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= ufds_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    ufds_front #(.NUM_ELEMENTS(NUM_ELEMENTS)) u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_count  (r_count),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_req    (w_in_req)
    );

    ufds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_in_req),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qv),
        .o_req   (w_q_req)
    );

    ufds_engine #(.NUM_ELEMENTS(NUM_ELEMENTS)) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(w_qv),
        .i_req    (w_q_req),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_root   (w_root),
        .o_joined (w_joined),
        .o_err    (m_axis_tuser)
    );

    assign m_axis_tdata = {5'd0, w_joined, w_root};
endmodule
